FILE: sv/sd_card_spi_host_engine_defines.svh
// assertion macros for the sd card spi host engine
`ifndef SD_CARD_SPI_HOST_ENGINE_DEFINES_SVH
`define SD_CARD_SPI_HOST_ENGINE_DEFINES_SVH

// a condition that must hold at every edge outside reset
`define SDH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// an implication whose consequent is checked in the next cycle
`define SDH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sdh_pkg.sv
// package for the sd card spi host engine: payload types, phases, codes
package sdh_pkg;

  localparam int SectorBytes       = 512;
  localparam int IdlePreambleBytes = 15;
  localparam logic [7:0] RetryLimitReset = 8'd200;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] sector_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } sdh_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       cs_level;
    logic       exchange;
    logic       want_data;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [3:0] status;
    logic [2:0] card_type;
    logic       slow_clock;
    logic [7:0] last_response;
  } sdh_out_t;

  typedef enum logic [1:0] {
    FN_INIT = 2'd0, FN_READ = 2'd1, FN_WRITE = 2'd2, FN_XCHG = 2'd3
  } sdh_func_t;

  typedef enum logic [4:0] {
    P_IDLE, P_PRE, P_CMD0, P_CMD8, P_R7, P_V2_55, P_V2_41, P_CMD58, P_OCR,
    P_V1_55, P_V1_41, P_V1L_55, P_V1L_41, P_CMD1, P_CMD16, P_TAIL_INIT,
    P_CMD17, P_RTOK, P_RDATA, P_RCRC, P_CMD24, P_WREADY, P_WDATA, P_WCRC,
    P_WRESP, P_WBUSY, P_TAIL
  } sdh_phase_t;

  typedef enum logic [2:0] {
    S_NONE, S_DESEL, S_READY, S_BYTES, S_POLL
  } sdh_stage_t;

  localparam logic [3:0] ST_OK = 4'd0, ST_CMD0 = 4'd1, ST_V2_41 = 4'd2,
    ST_V1_41 = 4'd3, ST_CMD1 = 4'd4, ST_CMD16 = 4'd5, ST_WTOK = 4'd6,
    ST_RCMD = 4'd7, ST_WCMD = 4'd8;

  localparam logic [2:0] CK_UNKNOWN = 3'd0, CK_SDV1 = 3'd1, CK_SDV2 = 3'd2,
    CK_SDHC = 3'd3, CK_MMC = 3'd4;

  localparam logic [7:0] CMD0 = 8'h40, CMD1 = 8'h41, CMD8 = 8'h48, CMD16 = 8'h50,
    CMD17 = 8'h51, CMD24 = 8'h58, CMD55 = 8'h77, ACMD41 = 8'h69, CMD58 = 8'h7A;
  localparam logic [7:0] IDLE_BYTE = 8'hFF, START_TOKEN = 8'hFE;

  localparam logic [0:0] REG_RETRY_LIMIT = 1'b0;

endpackage

FILE: sv/sd_card_spi_host_engine.sv
// top level of the sd card spi host engine: byte-level command sequencer
//
//   channel | ports                           | payload
//   in      | in_valid / in_ready / in_data   | sdh_in_t
//   out     | out_valid / out_ready / out_data| sdh_out_t
//   cfg     | psel penable pwrite paddr ...   | retry_limit at 0x0
//
// one item per cycle while out_ready drains the result: the sequencer state and
// result register update in the cycle the item is accepted, one result per item.
// in_ready is high whenever the result register is empty or being drained.
// rst_n is synchronous; it returns to idle with retry_limit at 200.
module sd_card_spi_host_engine
  import sdh_pkg::*;
#(
  parameter int SECTOR_BYTES        = SectorBytes,
  parameter int IDLE_PREAMBLE_BYTES = IdlePreambleBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sdh_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sdh_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
`include "sd_card_spi_host_engine_defines.svh"

  localparam int BW = $clog2(SECTOR_BYTES + 1);
  localparam logic [BW-1:0] SEC_N = BW'(SECTOR_BYTES);
  localparam logic [BW-1:0] PRE_N = BW'(IDLE_PREAMBLE_BYTES);

  logic [7:0]  retry_limit_r;
  sdh_phase_t  phase_r, phase_nxt;
  sdh_stage_t  stage_r, stage_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  retry_r, retry_nxt, poll_r, poll_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic [31:0] resp_r, resp_nxt, addr_r, addr_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        blk_r, blk_nxt, init_r, init_nxt, cs_r, cs_nxt;
  logic [7:0]  buf_r [6];
  logic [7:0]  buf_nxt [6];
  logic        out_valid_r;
  sdh_out_t    out_r, res;

  logic [7:0] lim;
  logic       accept;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:1] == REG_RETRY_LIMIT) ? {24'd0, retry_limit_r} : 32'd0;
  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign lim        = (retry_limit_r == 8'd0) ? 8'd1 : retry_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RetryLimitReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:1] == REG_RETRY_LIMIT) begin
      retry_limit_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    logic [7:0]  rx;
    logic [7:0]  rtr_inc;
    logic        bumped;
    logic        do_cmd;
    sdh_phase_t  c_ph;
    logic [7:0]  c_op;
    logic [31:0] c_arg;
    logic [7:0]  c_crc;
    logic        resp_ev;
    logic [31:0] sh;
    logic [BW-1:0] cinc;
    logic [7:0]  pinc;

    rx = in_data.rx_byte;
    phase_nxt = phase_r; stage_nxt = stage_r; idx_nxt = idx_r;
    retry_nxt = retry_r; poll_nxt = poll_r; cnt_nxt = cnt_r;
    resp_nxt = resp_r; addr_nxt = addr_r; kind_nxt = kind_r;
    blk_nxt = blk_r; init_nxt = init_r; cs_nxt = cs_r;
    buf_nxt = buf_r;
    res = '0;
    res.tx_byte = IDLE_BYTE;
    do_cmd = 1'b0; c_ph = P_IDLE; c_op = CMD0; c_arg = '0; c_crc = 8'h01;
    resp_ev = 1'b0;
    rtr_inc = retry_r + 8'd1;
    bumped = rtr_inc >= lim;
    sh = {resp_r[23:0], rx};
    cinc = cnt_r + BW'(1);
    pinc = poll_r + 8'd1;

    if (in_data.func != FN_XCHG) begin
      stage_nxt = S_NONE; retry_nxt = '0; poll_nxt = '0; cnt_nxt = '0; idx_nxt = '0;
      if (in_data.func == FN_INIT) begin
        init_nxt = 1'b1; kind_nxt = CK_UNKNOWN; blk_nxt = 1'b0;
        phase_nxt = P_PRE; cnt_nxt = BW'(1);
        res.exchange = 1'b1; cs_nxt = 1'b1;
      end else begin
        addr_nxt = blk_r ? in_data.sector_addr : {in_data.sector_addr[22:0], 9'd0};
        do_cmd = 1'b1; c_arg = addr_nxt;
        if (in_data.func == FN_READ) begin
          c_ph = P_CMD17; c_op = CMD17;
        end else begin
          c_ph = P_CMD24; c_op = CMD24; c_crc = 8'hFF;
        end
      end
    end else if (phase_r != P_IDLE) begin
      if (stage_r != S_NONE) begin
        res.exchange = 1'b1;
        case (stage_r)
          S_DESEL: begin
            stage_nxt = S_READY; cs_nxt = 1'b0;
          end
          S_READY: begin
            cs_nxt = 1'b0;
            if (rx == IDLE_BYTE) begin
              res.tx_byte = buf_r[0]; idx_nxt = 3'd1; stage_nxt = S_BYTES;
            end
          end
          S_BYTES: begin
            cs_nxt = 1'b0;
            if (idx_r < 3'd6) begin
              res.tx_byte = buf_r[idx_r]; idx_nxt = idx_r + 3'd1;
            end else begin
              stage_nxt = S_POLL; poll_nxt = '0;
            end
          end
          default: begin
            poll_nxt = pinc;
            if (rx == IDLE_BYTE && pinc < lim) begin
              cs_nxt = 1'b0;
            end else begin
              res.exchange = 1'b0; stage_nxt = S_NONE; resp_ev = 1'b1;
            end
          end
        endcase
      end else begin
        case (phase_r)
          P_PRE: begin
            if (cnt_r < PRE_N) begin
              cnt_nxt = cinc; res.exchange = 1'b1; cs_nxt = 1'b1;
            end else begin
              retry_nxt = '0; do_cmd = 1'b1; c_ph = P_CMD0; c_op = CMD0; c_crc = 8'h95;
            end
          end
          P_R7, P_OCR: begin
            resp_nxt = sh; cnt_nxt = cinc;
            if (cinc < BW'(4)) begin
              res.exchange = 1'b1; cs_nxt = 1'b0;
            end else if (phase_r == P_R7) begin
              do_cmd = 1'b1;
              if (sh[15:8] == 8'h01 && sh[7:0] == 8'hAA) begin
                retry_nxt = '0; c_ph = P_V2_55; c_op = CMD55;
              end else begin
                c_ph = P_CMD16; c_op = CMD16; c_arg = 32'h200;
              end
            end else begin
              if (sh[30]) begin
                kind_nxt = CK_SDHC; blk_nxt = 1'b1;
              end else begin
                kind_nxt = CK_SDV2;
              end
              do_cmd = 1'b1; c_ph = P_CMD16; c_op = CMD16; c_arg = 32'h200;
            end
          end
          P_RTOK: begin
            if (rx == START_TOKEN) begin
              phase_nxt = P_RDATA; cnt_nxt = '0;
            end
            res.exchange = 1'b1; cs_nxt = 1'b0;
          end
          P_RDATA: begin
            res.rd_valid = 1'b1; res.rd_byte = rx; cnt_nxt = cinc;
            if (cinc >= SEC_N) begin
              phase_nxt = P_RCRC; cnt_nxt = '0;
            end
            res.exchange = 1'b1; cs_nxt = 1'b0;
          end
          P_RCRC: begin
            cnt_nxt = cinc; res.exchange = 1'b1;
            if (cinc >= BW'(2)) begin
              phase_nxt = P_TAIL; cs_nxt = 1'b1;
            end else begin
              cs_nxt = 1'b0;
            end
          end
          P_WREADY: begin
            res.exchange = 1'b1; cs_nxt = 1'b0;
            if (rx == IDLE_BYTE) begin
              phase_nxt = P_WDATA; cnt_nxt = '0; res.tx_byte = START_TOKEN;
              res.want_data = 1'b1;
            end
          end
          P_WDATA: begin
            res.exchange = 1'b1; cs_nxt = 1'b0;
            if (cnt_r < SEC_N) begin
              res.tx_byte = in_data.wr_byte; cnt_nxt = cinc;
              res.want_data = cinc < SEC_N;
            end else begin
              phase_nxt = P_WCRC; cnt_nxt = '0;
            end
          end
          P_WCRC: begin
            cnt_nxt = cinc;
            if (cinc >= BW'(2)) phase_nxt = P_WRESP;
            res.exchange = 1'b1; cs_nxt = 1'b0;
          end
          P_WRESP: begin
            if (rx[4:0] != 5'h05) begin
              phase_nxt = P_IDLE; res.done_res = 1'b1; res.status = ST_WTOK;
            end else begin
              phase_nxt = P_WBUSY; res.exchange = 1'b1; cs_nxt = 1'b0;
            end
          end
          P_WBUSY: begin
            res.exchange = 1'b1;
            if (rx == IDLE_BYTE) begin
              phase_nxt = P_TAIL; cs_nxt = 1'b1;
            end else begin
              cs_nxt = 1'b0;
            end
          end
          P_TAIL_INIT: begin
            init_nxt = 1'b0; phase_nxt = P_IDLE; res.done_res = 1'b1;
          end
          P_TAIL: begin
            phase_nxt = P_IDLE; res.done_res = 1'b1;
          end
          default: ;
        endcase
      end
    end

    // response handling after the poll ends
    if (resp_ev) begin
      do_cmd = 1'b1;
      case (phase_r)
        P_CMD0: begin
          retry_nxt = rtr_inc;
          if (bumped) begin
            do_cmd = 1'b0; res.status = ST_CMD0;
          end else if (rx == 8'h01) begin
            c_ph = P_CMD8; c_op = CMD8; c_arg = 32'h1AA; c_crc = 8'h87;
          end else begin
            c_ph = P_CMD0; c_op = CMD0; c_crc = 8'h95;
          end
        end
        P_CMD8: begin
          if (rx == 8'h01) begin
            do_cmd = 1'b0; phase_nxt = P_R7; cnt_nxt = '0; resp_nxt = '0;
            res.exchange = 1'b1; cs_nxt = 1'b0;
          end else begin
            c_ph = P_V1_55; c_op = CMD55;
          end
        end
        P_V2_55: begin
          c_ph = P_V2_41; c_op = ACMD41; c_arg = 32'h4000_0000;
        end
        P_V2_41: begin
          retry_nxt = rtr_inc;
          if (bumped) begin
            do_cmd = 1'b0; res.status = ST_V2_41;
          end else if (rx == 8'h00) begin
            c_ph = P_CMD58; c_op = CMD58;
          end else begin
            c_ph = P_V2_55; c_op = CMD55;
          end
        end
        P_CMD58: begin
          if (rx == 8'h00) begin
            do_cmd = 1'b0; phase_nxt = P_OCR; cnt_nxt = '0; resp_nxt = '0;
            res.exchange = 1'b1; cs_nxt = 1'b0;
          end else begin
            c_ph = P_CMD16; c_op = CMD16; c_arg = 32'h200;
          end
        end
        P_V1_55: begin
          c_ph = P_V1_41; c_op = ACMD41;
        end
        P_V1_41: begin
          retry_nxt = '0;
          if (rx <= 8'h01) begin
            kind_nxt = CK_SDV1; c_ph = P_V1L_55; c_op = CMD55;
          end else begin
            kind_nxt = CK_MMC; c_ph = P_CMD1; c_op = CMD1;
          end
        end
        P_V1L_55: begin
          c_ph = P_V1L_41; c_op = ACMD41;
        end
        P_V1L_41, P_CMD1: begin
          retry_nxt = rtr_inc;
          if (bumped) begin
            do_cmd = 1'b0;
            res.status = (phase_r == P_CMD1) ? ST_CMD1 : ST_V1_41;
          end else if (rx == 8'h00) begin
            c_ph = P_CMD16; c_op = CMD16; c_arg = 32'h200;
          end else if (phase_r == P_CMD1) begin
            c_ph = P_CMD1; c_op = CMD1;
          end else begin
            c_ph = P_V1L_55; c_op = CMD55;
          end
        end
        P_CMD16: begin
          do_cmd = 1'b0;
          if (rx != 8'h00) begin
            kind_nxt = CK_UNKNOWN; res.status = ST_CMD16;
          end else begin
            phase_nxt = P_TAIL_INIT; res.exchange = 1'b1; cs_nxt = 1'b1;
          end
        end
        P_CMD17: begin
          retry_nxt = rtr_inc;
          if (bumped) begin
            do_cmd = 1'b0; res.status = ST_RCMD;
          end else if (rx == 8'h00) begin
            do_cmd = 1'b0; phase_nxt = P_RTOK; res.exchange = 1'b1; cs_nxt = 1'b0;
          end else begin
            c_ph = P_CMD17; c_op = CMD17; c_arg = addr_r;
          end
        end
        P_CMD24: begin
          retry_nxt = rtr_inc;
          if (bumped) begin
            do_cmd = 1'b0; res.status = ST_WCMD; res.last_response = rx;
          end else if (rx == 8'h00) begin
            do_cmd = 1'b0; phase_nxt = P_WREADY; res.exchange = 1'b1; cs_nxt = 1'b0;
          end else begin
            c_ph = P_CMD24; c_op = CMD24; c_arg = addr_r; c_crc = 8'hFF;
          end
        end
        default: begin
          do_cmd = 1'b0; res.status = ST_OK;
        end
      endcase
      if (!do_cmd && !res.exchange) begin
        phase_nxt = P_IDLE; res.done_res = 1'b1;
      end
    end

    if (do_cmd) begin
      phase_nxt = c_ph;
      buf_nxt[0] = c_op; buf_nxt[1] = c_arg[31:24]; buf_nxt[2] = c_arg[23:16];
      buf_nxt[3] = c_arg[15:8]; buf_nxt[4] = c_arg[7:0]; buf_nxt[5] = c_crc;
      stage_nxt = S_DESEL; idx_nxt = '0; poll_nxt = '0;
      res.exchange = 1'b1; res.tx_byte = IDLE_BYTE; cs_nxt = 1'b1;
    end

    res.cs_level   = cs_nxt;
    res.card_type  = kind_nxt;
    res.slow_clock = init_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; stage_r <= S_NONE; idx_r <= '0; retry_r <= '0;
      poll_r <= '0; cnt_r <= '0; resp_r <= '0; addr_r <= '0; kind_r <= CK_UNKNOWN;
      blk_r <= 1'b0; init_r <= 1'b0; cs_r <= 1'b1; out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt; stage_r <= stage_nxt; idx_r <= idx_nxt;
        retry_r <= retry_nxt; poll_r <= poll_nxt; cnt_r <= cnt_nxt;
        resp_r <= resp_nxt; addr_r <= addr_nxt; kind_r <= kind_nxt;
        blk_r <= blk_nxt; init_r <= init_nxt; cs_r <= cs_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r   <= res;
      buf_r   <= buf_nxt;
    end
  end

  `SDH_ASSERT_NEXT(a_one_result, accept, out_valid, "accepted item left no result")
  `SDH_ASSERT_ALWAYS(a_done_no_xchg, !(out_valid && out_r.done_res && out_r.exchange),
    "result both done and exchanging")
  `SDH_ASSERT_ALWAYS(a_idle_stage, !(phase_r == P_IDLE && stage_r != S_NONE),
    "command stage active while idle")
  `SDH_ASSERT_NEXT(a_hold, out_valid && !out_ready, $stable(out_r),
    "stalled result changed")

endmodule
